@@ rtl/dgto_pkg.sv @@
package dgto_pkg;

    localparam int MaxNodes = 32;
    localparam int MaxEdges = 64;
    localparam int KeyBits = 32;
    localparam int NodeIdxW = $clog2(MaxNodes);
    localparam int EdgeIdxW = $clog2(MaxEdges);
    localparam int NodeCntW = $clog2(MaxNodes + 1);
    localparam int EdgeCntW = $clog2(MaxEdges + 1);

    localparam logic [1:0] OP_ADD_NODE = 2'd0;
    localparam logic [1:0] OP_ADD_EDGE = 2'd1;
    localparam logic [1:0] OP_ORDER    = 2'd2;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_CAPACITY  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_CYCLE     = 3'd5;

endpackage

@@ rtl/dependency_graph_topological_order.sv @@
// Dependency graph builder with topological ordering.
// The input channel (s_axis_*) carries one command word: add node, add edge or
// compute order. The output channel (m_axis_*) returns result words; tlast marks
// the final word of each command. Add commands return one word, order commands
// one word per emitted node followed by a final status word.
// A command is processed by a sequencer that walks the node table and the edge
// table one entry at a time. Each table entry is first read into a register
// and then compared.
// Add node walks the node table; add edge walks the node table, then the edge
// table. Order walks the edge table to count in-degrees, then scans the nodes,
// and every emitted node walks the edge table to lower the in-degrees of its
// successors.
// s_axis_tready is high only while the sequencer is idle and the output
// register is empty or its word is being taken.
// A result word sits in an output register; when the receiver stalls, the
// sequencer waits on that register and resumes once the word is taken.
// Reset clears the node count, edge count and revision counter, emptying the
// graph; node and edge table contents need no clearing.
module dependency_graph_topological_order (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], producer_key[33:2], consumer_key[65:34], language[69:66], room[75:70]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], node_slot[8:3], emitted_count[14:9], revision[46:15]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int NW = dgto_pkg::NodeIdxW;
    localparam int EW = dgto_pkg::EdgeIdxW;
    localparam int NC = dgto_pkg::NodeCntW;
    localparam int EC = dgto_pkg::EdgeCntW;
    localparam int KB = dgto_pkg::KeyBits;

    typedef enum logic [3:0] {
        S_IDLE, S_NFIND, S_EFIND, S_EDUP, S_CNT, S_SCAN, S_DEC, S_OUT
    } state_t;

    state_t state_reg;
    logic [KB-1:0] node_keys [dgto_pkg::MaxNodes];
    logic [NW-1:0] edge_from [dgto_pkg::MaxEdges];
    logic [NW-1:0] edge_to [dgto_pkg::MaxEdges];
    logic [EC-1:0] pend_reg [dgto_pkg::MaxNodes];
    logic [dgto_pkg::MaxNodes-1:0] done_reg;

    logic [NC-1:0] node_total_reg;
    logic [EC-1:0] edge_total_reg;
    logic [31:0] rev_reg;
    logic [KB-1:0] pkey_reg, ckey_reg;
    logic [NC-1:0] ni_reg;
    logic [EC-1:0] ei_reg;
    logic [NW-1:0] p_reg, c_reg, cur_reg;
    logic p_found_reg, c_found_reg, progress_reg, fin_reg;
    logic rd_ok_reg;
    logic [NC-1:0] emitted_reg;
    logic out_valid_reg, out_last_reg;
    logic [2:0] out_st_reg;
    logic [5:0] out_slot_reg, out_cnt_reg;

    logic [1:0] in_op;
    logic [KB-1:0] in_pkey, in_ckey;
    logic [3:0] in_lang;
    logic [5:0] in_room;
    assign in_op = s_axis_tdata[1:0];
    assign in_pkey = s_axis_tdata[2 +: KB];
    assign in_ckey = s_axis_tdata[34 +: KB];
    assign in_lang = s_axis_tdata[69:66];
    assign in_room = s_axis_tdata[75:70];

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tdata = {1'b0, rev_reg, out_cnt_reg, out_slot_reg, out_st_reg};

    logic [KB-1:0] nkey_reg;
    logic [NW-1:0] ni_idx, ef_reg, et_reg;
    logic [EW-1:0] ei_idx;
    assign ni_idx = ni_reg[NW-1:0];
    assign ei_idx = ei_reg[EW-1:0];

    always_ff @(posedge clk)
    begin
        nkey_reg <= node_keys[ni_idx];
        ef_reg <= edge_from[ei_idx];
        et_reg <= edge_to[ei_idx];
        if (state_reg == S_NFIND && ni_reg == node_total_reg && pkey_reg != '0
            && node_total_reg < NC'(dgto_pkg::MaxNodes))
        begin
            node_keys[node_total_reg[NW-1:0]] <= pkey_reg;
        end
        if (state_reg == S_EDUP && ei_reg == edge_total_reg
            && edge_total_reg < EC'(dgto_pkg::MaxEdges))
        begin
            edge_from[edge_total_reg[EW-1:0]] <= p_reg;
            edge_to[edge_total_reg[EW-1:0]] <= c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            node_total_reg <= '0;
            edge_total_reg <= '0;
            rev_reg <= '0;
            out_valid_reg <= 1'b0;
            done_reg <= '0;
        end
        else
        begin
            logic out_set;
            out_set = 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        pkey_reg <= in_pkey;
                        ckey_reg <= in_ckey;
                        ni_reg <= '0;
                        ei_reg <= '0;
                        rd_ok_reg <= 1'b0;
                        p_found_reg <= 1'b0;
                        c_found_reg <= 1'b0;
                        emitted_reg <= '0;
                        out_slot_reg <= '0;
                        out_cnt_reg <= '0;
                        out_last_reg <= 1'b1;
                        fin_reg <= 1'b1;
                        if (in_op == dgto_pkg::OP_ADD_NODE)
                        begin
                            if (in_pkey == '0 || in_lang == 4'd0)
                            begin
                                out_st_reg <= dgto_pkg::ST_INVALID;
                                out_set = 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_NFIND;
                            end
                        end
                        else if (in_op == dgto_pkg::OP_ADD_EDGE)
                        begin
                            if (in_pkey == '0 || in_ckey == '0)
                            begin
                                out_st_reg <= dgto_pkg::ST_INVALID;
                                out_set = 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_EFIND;
                            end
                        end
                        else if (in_op == dgto_pkg::OP_ORDER)
                        begin
                            if (NC'(in_room) < node_total_reg)
                            begin
                                out_st_reg <= dgto_pkg::ST_INVALID;
                                out_set = 1'b1;
                            end
                            else
                            begin
                                done_reg <= '0;
                                for (int k = 0; k < dgto_pkg::MaxNodes; k++)
                                begin
                                    pend_reg[k] <= '0;
                                end
                                state_reg <= S_CNT;
                            end
                        end
                        else
                        begin
                            out_st_reg <= dgto_pkg::ST_INVALID;
                            out_set = 1'b1;
                        end
                    end
                end
                S_NFIND:
                begin
                    if (ni_reg == node_total_reg)
                    begin
                        if (node_total_reg >= NC'(dgto_pkg::MaxNodes))
                        begin
                            out_st_reg <= dgto_pkg::ST_CAPACITY;
                        end
                        else
                        begin
                            out_st_reg <= dgto_pkg::ST_OK;
                            node_total_reg <= node_total_reg + 1'b1;
                            rev_reg <= rev_reg + 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else if (nkey_reg == pkey_reg)
                    begin
                        out_st_reg <= dgto_pkg::ST_EXISTS;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ni_reg <= ni_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                end
                S_EFIND:
                begin
                    if (ni_reg == node_total_reg)
                    begin
                        if (!p_found_reg || !c_found_reg)
                        begin
                            out_st_reg <= dgto_pkg::ST_NOT_FOUND;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_EDUP;
                        end
                    end
                    else if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        if (!p_found_reg && nkey_reg == pkey_reg)
                        begin
                            p_found_reg <= 1'b1;
                            p_reg <= ni_idx;
                        end
                        if (!c_found_reg && nkey_reg == ckey_reg)
                        begin
                            c_found_reg <= 1'b1;
                            c_reg <= ni_idx;
                        end
                        ni_reg <= ni_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                end
                S_EDUP:
                begin
                    if (ei_reg == edge_total_reg)
                    begin
                        if (edge_total_reg >= EC'(dgto_pkg::MaxEdges))
                        begin
                            out_st_reg <= dgto_pkg::ST_CAPACITY;
                        end
                        else
                        begin
                            out_st_reg <= dgto_pkg::ST_OK;
                            edge_total_reg <= edge_total_reg + 1'b1;
                            rev_reg <= rev_reg + 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else if (ef_reg == p_reg && et_reg == c_reg)
                    begin
                        out_st_reg <= dgto_pkg::ST_EXISTS;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ei_reg <= ei_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                end
                S_CNT:
                begin
                    if (ei_reg == edge_total_reg)
                    begin
                        ni_reg <= '0;
                        progress_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                    else if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg[et_reg] <= pend_reg[et_reg] + 1'b1;
                        ei_reg <= ei_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (emitted_reg == node_total_reg)
                    begin
                        if (out_free)
                        begin
                            out_st_reg <= dgto_pkg::ST_OK;
                            out_slot_reg <= '0;
                            out_cnt_reg <= 6'(emitted_reg);
                            out_last_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                    else if (ni_reg == node_total_reg)
                    begin
                        if (!progress_reg)
                        begin
                            if (out_free)
                            begin
                                out_st_reg <= dgto_pkg::ST_CYCLE;
                                out_slot_reg <= '0;
                                out_cnt_reg <= 6'(emitted_reg);
                                out_last_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                        end
                        else
                        begin
                            ni_reg <= '0;
                            progress_reg <= 1'b0;
                        end
                    end
                    else if (!done_reg[ni_idx] && pend_reg[ni_idx] == '0)
                    begin
                        if (out_free)
                        begin
                            done_reg[ni_idx] <= 1'b1;
                            emitted_reg <= emitted_reg + 1'b1;
                            progress_reg <= 1'b1;
                            cur_reg <= ni_idx;
                            out_st_reg <= dgto_pkg::ST_OK;
                            out_slot_reg <= 6'(ni_idx);
                            out_cnt_reg <= 6'(emitted_reg + 1'b1);
                            out_last_reg <= 1'b0;
                            out_set = 1'b1;
                            ei_reg <= '0;
                            rd_ok_reg <= 1'b0;
                            state_reg <= S_DEC;
                        end
                    end
                    else
                    begin
                        ni_reg <= ni_reg + 1'b1;
                    end
                end
                S_DEC:
                begin
                    if (ei_reg == edge_total_reg)
                    begin
                        ni_reg <= ni_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        if (ef_reg == cur_reg && pend_reg[et_reg] != '0)
                        begin
                            pend_reg[et_reg] <= pend_reg[et_reg] - 1'b1;
                        end
                        ei_reg <= ei_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_set = 1'b1;
                        out_last_reg <= fin_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            out_valid_reg <= out_set || (out_valid_reg && !m_axis_tready);
        end
    end

endmodule

@@ rtl/dgto_checker.sv @@
module dgto_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result word holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Status codes above cycle never appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= dgto_pkg::ST_CYCLE)
        else $error("bad status code");

    // A non-final word is always an ok emission.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[2:0] == dgto_pkg::ST_OK)
        else $error("non-final word with error status");

    // Right after a command is taken, another one is taken only while a result word leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready || (m_axis_tvalid && m_axis_tready))
        else $error("command taken while the output register was busy");

endmodule

bind dependency_graph_topological_order dgto_checker u_dgto_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);

@@ bench/tb.sv @@
module tb;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  node_slot;
        logic [5:0]  emitted_count;
        logic [31:0] revision;
        logic        last;
    } graph_result_t;

    class order_scoreboard;
        logic [31:0] keys[dgto_pkg::MaxNodes];
        int unsigned n_nodes;
        int unsigned edge_from[dgto_pkg::MaxEdges];
        int unsigned edge_to[dgto_pkg::MaxEdges];
        int unsigned n_edges;
        logic [31:0] revision;
        graph_result_t pending[$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned orders_seen;
        int unsigned cycles_seen;

        function new();
            n_nodes = 0;
            n_edges = 0;
            revision = 0;
            mismatches = 0;
            results_seen = 0;
            orders_seen = 0;
            cycles_seen = 0;
        endfunction

        function int find_key(logic [31:0] key);
            for (int i = 0; i < n_nodes; i++)
                if (keys[i] == key)
                    return i;
            return -1;
        endfunction

        function void push(logic [2:0] st, int slot, int cnt, logic lst);
            graph_result_t r;
            r.status = st;
            r.node_slot = slot[5:0];
            r.emitted_count = cnt[5:0];
            r.revision = revision;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function logic [2:0] add_node(logic [31:0] key, logic [3:0] lang);
            if (key == 0 || lang == 0)
                return dgto_pkg::ST_INVALID;
            if (find_key(key) >= 0)
                return dgto_pkg::ST_EXISTS;
            if (n_nodes >= dgto_pkg::MaxNodes)
                return dgto_pkg::ST_CAPACITY;
            keys[n_nodes] = key;
            n_nodes++;
            revision++;
            return dgto_pkg::ST_OK;
        endfunction

        function logic [2:0] add_edge(logic [31:0] pk, logic [31:0] ck);
            int p;
            int c;
            if (pk == 0 || ck == 0)
                return dgto_pkg::ST_INVALID;
            p = find_key(pk);
            c = find_key(ck);
            if (p < 0 || c < 0)
                return dgto_pkg::ST_NOT_FOUND;
            for (int e = 0; e < n_edges; e++)
                if (edge_from[e] == p && edge_to[e] == c)
                    return dgto_pkg::ST_EXISTS;
            if (n_edges >= dgto_pkg::MaxEdges)
                return dgto_pkg::ST_CAPACITY;
            edge_from[n_edges] = p;
            edge_to[n_edges] = c;
            n_edges++;
            revision++;
            return dgto_pkg::ST_OK;
        endfunction

        function void sort_graph(int unsigned room);
            int unsigned indeg[dgto_pkg::MaxNodes];
            bit done[dgto_pkg::MaxNodes];
            int unsigned emitted;
            bit progress;
            orders_seen++;
            if (room < n_nodes)
            begin
                push(dgto_pkg::ST_INVALID, 0, 0, 1'b1);
                return;
            end
            for (int i = 0; i < dgto_pkg::MaxNodes; i++)
            begin
                indeg[i] = 0;
                done[i] = 0;
            end
            for (int e = 0; e < n_edges; e++)
                indeg[edge_to[e]]++;
            emitted = 0;
            while (emitted < n_nodes)
            begin
                progress = 0;
                for (int i = 0; i < n_nodes; i++)
                begin
                    if (done[i] || indeg[i] != 0)
                        continue;
                    done[i] = 1;
                    emitted++;
                    progress = 1;
                    push(dgto_pkg::ST_OK, i, emitted, 1'b0);
                    for (int e = 0; e < n_edges; e++)
                        if (edge_from[e] == i && indeg[edge_to[e]] > 0)
                            indeg[edge_to[e]]--;
                end
                if (!progress)
                begin
                    cycles_seen++;
                    push(dgto_pkg::ST_CYCLE, 0, emitted, 1'b1);
                    return;
                end
            end
            push(dgto_pkg::ST_OK, 0, emitted, 1'b1);
        endfunction

        function void note_command(logic [79:0] word);
            logic [1:0] op;
            logic [2:0] st;
            op = word[1:0];
            if (op == dgto_pkg::OP_ORDER)
                sort_graph(32'(word[75:70]));
            else
            begin
                if (op == dgto_pkg::OP_ADD_NODE)
                    st = add_node(word[33:2], word[69:66]);
                else if (op == dgto_pkg::OP_ADD_EDGE)
                    st = add_edge(word[33:2], word[65:34]);
                else
                    st = dgto_pkg::ST_INVALID;
                push(st, 0, 0, 1'b1);
            end
        endfunction

        function void check_result(logic [47:0] word, logic lst);
            graph_result_t exp_r;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %h last %b", word, lst);
                return;
            end
            exp_r = pending.pop_front();
            if (word[2:0] !== exp_r.status || word[8:3] !== exp_r.node_slot
                || word[14:9] !== exp_r.emitted_count || word[46:15] !== exp_r.revision
                || lst !== exp_r.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: got st %0d slot %0d cnt %0d rev %0d last %b,",
                             word[2:0], word[8:3], word[14:9], word[46:15], lst);
                    $display("       expected st %0d slot %0d cnt %0d rev %0d last %b",
                             exp_r.status, exp_r.node_slot, exp_r.emitted_count,
                             exp_r.revision, exp_r.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    order_scoreboard sb;
    logic [31:0] key_pool[$];
    int unsigned gap_left;
    int unsigned stall_mode;

    dependency_graph_topological_order u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver alternates between phases of no stalling, light and heavy stalling.
    initial
    begin
        m_axis_tready = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);

    task automatic send_word(logic [1:0] op, logic [31:0] pk, logic [31:0] ck,
                             logic [3:0] lang, logic [5:0] room);
        logic [79:0] word;
        int unsigned idle_cycles;
        word = {4'b0, room, lang, ck, pk, op};
        if (gap_left == 0)
        begin
            gap_left = $urandom_range(1, 8);
            idle_cycles = $urandom_range(0, 6);
            if (idle_cycles != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (idle_cycles) @(posedge clk);
            end
        end
        gap_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(word);
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() == 0 || $urandom_range(0, 9) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    task automatic add_fresh_node();
        logic [31:0] k;
        k = $urandom();
        if (k == 0)
            k = 1;
        key_pool.push_back(k);
        send_word(dgto_pkg::OP_ADD_NODE, k, $urandom(), 4'($urandom_range(1, 15)),
                  6'($urandom()));
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        gap_left = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(dgto_pkg::OP_ORDER, 0, 0, 0, 0);
        send_word(dgto_pkg::OP_ADD_NODE, 0, 0, 4'hF, 0);
        send_word(dgto_pkg::OP_ADD_NODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 6'h3F);
        send_word(dgto_pkg::OP_ADD_NODE, 32'hFFFF_FFFF, 0, 4'hF, 0);
        send_word(dgto_pkg::OP_ADD_NODE, 32'hFFFF_FFFF, 0, 4'h1, 0);
        send_word(dgto_pkg::OP_ADD_NODE, 32'h0000_0001, 0, 4'h1, 0);
        send_word(dgto_pkg::OP_ADD_NODE, 32'h8000_0000, 0, 4'h2, 0);
        key_pool.push_back(32'hFFFF_FFFF);
        key_pool.push_back(32'h0000_0001);
        key_pool.push_back(32'h8000_0000);
        send_word(dgto_pkg::OP_ADD_EDGE, 0, 1, 0, 0);
        send_word(dgto_pkg::OP_ADD_EDGE, 1, 0, 0, 0);
        send_word(dgto_pkg::OP_ADD_EDGE, 1, 32'h1234, 0, 0);
        send_word(dgto_pkg::OP_ADD_EDGE, 32'hFFFF_FFFF, 1, 0, 0);
        send_word(dgto_pkg::OP_ADD_EDGE, 32'hFFFF_FFFF, 1, 0, 0);
        send_word(dgto_pkg::OP_ADD_EDGE, 1, 32'h8000_0000, 0, 0);
        send_word(dgto_pkg::OP_ORDER, 0, 0, 0, 2);
        send_word(dgto_pkg::OP_ORDER, 0, 0, 0, 6'h3F);
        send_word(dgto_pkg::OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 6'h3F);
        send_word(dgto_pkg::OP_ADD_EDGE, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_word(dgto_pkg::OP_ORDER, 0, 0, 0, 3);
        drain();

        // Fresh graphs need a reset, so keep filling this one with a random mix of node
        // and edge additions towards their limits, ordering along the way.
        for (int n = 0; n < 160; n++)
        begin
            int unsigned r;
            r = $urandom_range(0, 99);
            if (sb.n_nodes < dgto_pkg::MaxNodes && r < 30)
                add_fresh_node();
            else if (r < 75)
                send_word(dgto_pkg::OP_ADD_EDGE, pick_key(), pick_key(), 0, 0);
            else if (r < 82)
                send_word(dgto_pkg::OP_ORDER, $urandom(), $urandom(), 4'($urandom()),
                          6'($urandom_range(sb.n_nodes, 63)));
            else if (r < 87)
                send_word(dgto_pkg::OP_ORDER, 0, 0, 0, 6'($urandom()));
            else if (r < 95)
                send_word(dgto_pkg::OP_ADD_NODE, pick_key(), $urandom(), 4'($urandom()),
                          6'($urandom()));
            else
                send_word(2'($urandom()), $urandom(), $urandom(), 4'($urandom()),
                          6'($urandom()));
        end
        send_word(dgto_pkg::OP_ORDER, 0, 0, 0, 6'h3F);
        drain();

        $display("Run covered %0d result words over %0d order commands (%0d cycles found).",
                 sb.results_seen, sb.orders_seen, sb.cycles_seen);
        $display("Final graph: %0d nodes, %0d edges.", sb.n_nodes, sb.n_edges);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/dgto_pkg.sv
rtl/dependency_graph_topological_order.sv
rtl/dgto_checker.sv
bench/tb.sv
